// ===== hdl/gmed_pkg.sv =====
// ----------------------------------------------------------------------------
// gmed_pkg
// Shared constants, FSM state type and controller command bundle for the
// gated running median block.
// ----------------------------------------------------------------------------
package gmed_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    // window_length register
    localparam int                  CFG_BITS  = 7;
    localparam logic [CFG_BITS-1:0] LEN_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_SWEEP,
        S_DRAIN,
        S_FLUSH,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;    // latch incoming sample
        logic old_rd;    // write ring slot, fetch evicted value, init merge
        logic sweep_rd;  // read one sorted entry
        logic flush;     // emit the insertion carry as the last entry
        logic finish;    // form median, swap sorted banks
        logic load_out;  // move held median into the output register
    } t_cmd;

endpackage

// ===== hdl/gmed_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmed_ctrl
// Controller FSM: input/output handshake, sweep address counter and the
// per-cycle commands for the datapath.
// ----------------------------------------------------------------------------
module gmed_ctrl #(
    parameter  int MAX_WINDOW = gmed_pkg::MAX_WINDOW_DEF,
    localparam int IW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_trigger,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  logic [IW-1:0]   i_last_idx,
    output logic [IW-1:0]   o_rd_addr,
    output gmed_pkg::t_cmd  o_cmd
);

    gmed_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_rd_idx;
    logic             r_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gmed_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_trigger ? gmed_pkg::S_OLD : gmed_pkg::S_DONE;
                end
            end
            gmed_pkg::S_OLD:    n_state = gmed_pkg::S_SWEEP;
            gmed_pkg::S_SWEEP: begin
                if (r_rd_idx == i_last_idx) begin
                    n_state = gmed_pkg::S_DRAIN;
                end
            end
            gmed_pkg::S_DRAIN:  n_state = gmed_pkg::S_FLUSH;
            gmed_pkg::S_FLUSH:  n_state = gmed_pkg::S_FINISH;
            gmed_pkg::S_FINISH: n_state = gmed_pkg::S_DONE;
            gmed_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = gmed_pkg::S_IDLE;
                end
            end
            default:            n_state = gmed_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            gmed_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            gmed_pkg::S_OLD:    o_cmd.old_rd   = 1'b1;
            gmed_pkg::S_SWEEP:  o_cmd.sweep_rd = 1'b1;
            gmed_pkg::S_DRAIN:  o_cmd          = '0;
            gmed_pkg::S_FLUSH:  o_cmd.flush    = 1'b1;
            gmed_pkg::S_FINISH: o_cmd.finish   = 1'b1;
            gmed_pkg::S_DONE:   o_cmd.load_out = out_free;
            default:            o_cmd          = '0;
        endcase
    end

    assign o_rd_addr   = r_rd_idx;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gmed_pkg::S_IDLE;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.old_rd) begin
                r_rd_idx <= '0;
            end else if (o_cmd.sweep_rd) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/gmed_dpath.sv =====
// ----------------------------------------------------------------------------
// gmed_dpath
// Datapath: sample ring, double-banked sorted store, streaming
// remove/insert merge, median capture and the output register.
// ----------------------------------------------------------------------------
module gmed_dpath #(
    parameter  int MAX_WINDOW  = gmed_pkg::MAX_WINDOW_DEF,
    parameter  int SAMPLE_BITS = gmed_pkg::SAMPLE_BITS_DEF,
    localparam int IW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int LW          = $clog2(MAX_WINDOW + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [gmed_pkg::CFG_BITS-1:0]  i_cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  gmed_pkg::t_cmd                 i_cmd,
    input  logic [IW-1:0]                  i_rd_addr,
    output logic [IW-1:0]                  o_last_idx,
    output logic signed [SAMPLE_BITS-1:0]  o_median_value
);

    localparam int RING_DEPTH = 2 ** IW;
    localparam int SORT_DEPTH = 2 ** (IW + 1);

    logic [gmed_pkg::CFG_BITS-1:0] r_len_cfg;
    logic [LW-1:0]                 len_eff;
    logic [IW-1:0]                 mid_lo;

    logic [IW-1:0]                 r_pos;
    logic                          r_wrapped;
    logic                          r_zero;
    logic                          r_bank;
    logic                          r_removed;
    logic                          r_rd_valid;
    logic [IW-1:0]                 r_wr_idx;

    logic signed [SAMPLE_BITS-1:0] r_ring   [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_sorted [SORT_DEPTH];

    logic signed [SAMPLE_BITS-1:0] r_sample, r_carry, r_old, r_rd_data;
    logic signed [SAMPLE_BITS-1:0] r_lo, r_hi, r_held, r_out;

    logic signed [SAMPLE_BITS-1:0] rd_val, emit_val, median;
    logic signed [SAMPLE_BITS:0]   pair_sum;
    logic                          skip, gt, emit_en;

    // length clamp: 0 acts as 1, oversize acts as MAX_WINDOW
    always_comb begin
        if (r_len_cfg == '0) begin
            len_eff = LW'(1);
        end else if (32'(r_len_cfg) > 32'(MAX_WINDOW)) begin
            len_eff = LW'(MAX_WINDOW);
        end else begin
            len_eff = LW'(r_len_cfg);
        end
    end

    assign o_last_idx = IW'(len_eff - LW'(1));
    assign mid_lo     = IW'((len_eff - LW'(1)) >> 1);

    // merge step: drop first copy of the evicted value, bubble the new one in
    assign rd_val   = r_zero ? '0 : r_rd_data;
    assign skip     = r_rd_valid && !r_removed && (rd_val == r_old);
    assign gt       = rd_val > r_carry;
    assign emit_en  = i_cmd.flush || (r_rd_valid && !skip);
    assign emit_val = (i_cmd.flush || gt) ? r_carry : rd_val;

    assign pair_sum = {r_lo[SAMPLE_BITS-1], r_lo} + {r_hi[SAMPLE_BITS-1], r_hi};
    assign median   = len_eff[0] ? r_lo : pair_sum[SAMPLE_BITS:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg  <= gmed_pkg::LEN_RESET;
            r_pos      <= '0;
            r_wrapped  <= 1'b0;
            r_zero     <= 1'b1;
            r_bank     <= 1'b0;
            r_removed  <= 1'b0;
            r_rd_valid <= 1'b0;
            r_held     <= '0;
        end else if (i_cfg_wr_en) begin
            r_len_cfg  <= i_cfg_wr_data;
            r_pos      <= '0;
            r_wrapped  <= 1'b0;
            r_zero     <= 1'b1;
            r_held     <= '0;
        end else begin
            r_rd_valid <= i_cmd.sweep_rd;
            if (i_cmd.old_rd) begin
                r_removed <= 1'b0;
                if (r_pos == o_last_idx) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (skip) begin
                r_removed <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_held <= median;
                r_bank <= ~r_bank;
                r_zero <= 1'b0;
            end
        end
    end

    // ring: evicted value comes back only once the slot has been written
    always_ff @(posedge i_clk) begin
        if (i_cmd.old_rd) begin
            r_old        <= r_wrapped ? r_ring[r_pos] : '0;
            r_ring[r_pos] <= r_sample;
        end
    end

    // sorted store: read one bank, write the other
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_rd) begin
            r_rd_data <= r_sorted[{r_bank, i_rd_addr}];
        end
        if (emit_en) begin
            r_sorted[{~r_bank, r_wr_idx}] <= emit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.old_rd) begin
            r_carry  <= r_sample;
            r_wr_idx <= '0;
        end else begin
            if (r_rd_valid && !skip && gt) begin
                r_carry <= rd_val;
            end
            if (emit_en) begin
                r_wr_idx <= r_wr_idx + 1'b1;
            end
        end
        if (emit_en && (r_wr_idx == mid_lo)) begin
            r_lo <= emit_val;
        end
        if (emit_en && ({1'b0, r_wr_idx} == ({1'b0, mid_lo} + 1'b1))) begin
            r_hi <= emit_val;
        end
        if (i_cmd.load_out) begin
            r_out <= r_held;
        end
    end

    assign o_median_value = r_out;

endmodule

// ===== hdl/gated_running_median.sv =====
// ----------------------------------------------------------------------------
// gated_running_median
// Running median over the most recent triggered samples, with a gate that
// repeats the last median when the trigger is clear.
// ----------------------------------------------------------------------------
// Sequence: triggered transaction S_OLD, sweep over L entries (L = effective
//   window length), S_DRAIN, S_FLUSH, S_FINISH, S_DONE; untriggered: S_DONE.
//   A new sample waits for S_IDLE. The pace is set by the sweep over the
//   sorted store, one entry per cycle through its single read port.
// Reset (sync, active low): controller idle, window_length 64, window all
//   zero, held median zero. No clearing pass; output register may hold old
//   data until the first result is loaded.
// ----------------------------------------------------------------------------
//
// Structure
//   The window is kept twice: a ring in arrival order (to know which value
//   leaves) and a sorted copy in two banks. Each triggered sample runs one
//   streaming merge pass: entries are read from the active bank in order,
//   the first copy of the evicted value is dropped, the new sample is
//   carried along until a larger entry appears, and every emitted entry is
//   written in order to the other bank. The middle one or two entries are
//   caught as they pass, and the banks swap at the end.
//
//   Zeros not yet overwritten are handled without per-entry flags: the ring
//   reports an evicted zero until it has wrapped once, and the sorted store
//   reads as zero until the first pass after a clear has filled a bank.
//
//   Even lengths average the two middle entries in SAMPLE_BITS+1 bits and
//   halve by an arithmetic shift (rounds toward minus infinity).
//
//   The output register lets one finished result wait while the next
//   transaction is accepted and computed.
module gated_running_median #(
    parameter int MAX_WINDOW  = gmed_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = gmed_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // window_length register
    input  logic                           i_cfg_wr_en,
    input  logic [gmed_pkg::CFG_BITS-1:0]  i_cfg_wr_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic                           i_trigger,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]  o_median_value
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    gmed_pkg::t_cmd cmd;
    logic [IW-1:0]  last_idx;
    logic [IW-1:0]  rd_addr;

    // sequencing and handshakes
    gmed_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_trigger   (i_trigger),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_last_idx  (last_idx),
        .o_rd_addr   (rd_addr),
        .o_cmd       (cmd)
    );

    // storage, merge and median arithmetic
    gmed_dpath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .o_last_idx     (last_idx),
        .o_median_value (o_median_value)
    );

endmodule

// ===== hdl/gmed_checker.sv =====
// ----------------------------------------------------------------------------
// gmed_checker
// Port-level checks for gated_running_median, bound to the top level.
// ----------------------------------------------------------------------------
module gmed_checker #(
    parameter int SAMPLE_BITS = gmed_pkg::SAMPLE_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_wr_en,
    input logic [gmed_pkg::CFG_BITS-1:0]  i_cfg_wr_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic signed [SAMPLE_BITS-1:0]  i_sample,
    input logic                           i_trigger,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_BITS-1:0]  o_median_value
);

    logic                          in_fire, out_fire;
    logic [1:0]                    r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_q_smp [2];
    logic                          r_q_trg [2];
    logic signed [SAMPLE_BITS-1:0] r_last;
    logic [gmed_pkg::CFG_BITS-1:0] r_len;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // at most two transactions in flight: one computing, one waiting at output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= '0;
            r_len  <= gmed_pkg::LEN_RESET;
        end else begin
            if (in_fire && out_fire) begin
                if (r_cnt == 2'd2) begin
                    r_q_smp[0] <= r_q_smp[1];
                    r_q_trg[0] <= r_q_trg[1];
                    r_q_smp[1] <= i_sample;
                    r_q_trg[1] <= i_trigger;
                end else begin
                    r_q_smp[0] <= i_sample;
                    r_q_trg[0] <= i_trigger;
                end
            end else if (in_fire) begin
                if (r_cnt == 2'd0) begin
                    r_q_smp[0] <= i_sample;
                    r_q_trg[0] <= i_trigger;
                end else begin
                    r_q_smp[1] <= i_sample;
                    r_q_trg[1] <= i_trigger;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (out_fire) begin
                r_q_smp[0] <= r_q_smp[1];
                r_q_trg[0] <= r_q_trg[1];
                r_cnt      <= r_cnt - 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_last <= '0;
                r_len  <= i_cfg_wr_data;
            end else if (out_fire) begin
                r_last <= o_median_value;
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_median_value))
        else $error("stalled result dropped or changed");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> r_cnt != 2'd0)
        else $error("result delivered without an accepted transaction");

    a_gate_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_cnt != 2'd0 && !r_q_trg[0] |-> o_median_value == r_last)
        else $error("untriggered transaction did not repeat held median");

    a_len_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && r_cnt != 2'd0 && r_q_trg[0] && r_len <= 7'd1
        |-> o_median_value == r_q_smp[0])
        else $error("window of one did not return the sample");

endmodule

bind gated_running_median gmed_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gmed_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_wr_en    (i_cfg_wr_en),
    .i_cfg_wr_data  (i_cfg_wr_data),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_sample       (i_sample),
    .i_trigger      (i_trigger),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_median_value (o_median_value)
);

// ===== dv/gated_running_median_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_running_median_check
// Passive checker: follows the window_length writes and the input
// transactions, keeps its own copy of the sample ring, predicts the median
// for each transaction and compares it with each output transaction.
// ----------------------------------------------------------------------------
module gated_running_median_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [gmed_pkg::CFG_BITS-1:0]      i_cfg_wr_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [gmed_pkg::SAMPLE_BITS_DEF-1:0] i_sample,
    input  logic                               i_trigger,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [gmed_pkg::SAMPLE_BITS_DEF-1:0] i_median_value,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_item_count,
    output int                                 o_result_count
);

    localparam int SB      = gmed_pkg::SAMPLE_BITS_DEF;
    localparam int WIN_MAX = gmed_pkg::MAX_WINDOW_DEF;

    logic signed [SB-1:0]              ring [WIN_MAX];
    int unsigned                       slot_ptr;
    logic signed [SB-1:0]              last_median;
    logic [gmed_pkg::CFG_BITS-1:0]     win_len;
    logic signed [SB-1:0]              pending_medians [$];
    int                                fails;
    int                                items;
    int                                results;

    // zero acts as one, anything above the store size acts as the store size
    function automatic int unsigned active_length();
        if (win_len == 0)
            return 1;
        if (win_len > WIN_MAX)
            return WIN_MAX;
        return win_len;
    endfunction

    function automatic void clear_ring();
        foreach (ring[k])
            ring[k] = '0;
        slot_ptr    = 0;
        last_median = '0;
    endfunction

    function automatic logic signed [SB-1:0] ring_median(int unsigned n);
        logic signed [SB-1:0] srt [WIN_MAX];
        logic signed [SB:0]   pair_sum;
        logic signed [SB-1:0] v;
        int                   j;
        for (int i = 0; i < n; i++) begin
            v = ring[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (n % 2 == 1)
            return srt[(n-1)/2];
        // even: exact sum one bit wider, floor halving
        pair_sum = srt[n/2-1] + srt[n/2];
        return pair_sum[SB:1];
    endfunction

    function automatic logic signed [SB-1:0] take_sample(logic signed [SB-1:0] s, logic trig);
        int unsigned n;
        n = active_length();
        if (trig) begin
            if (slot_ptr >= n)
                slot_ptr = 0;
            ring[slot_ptr] = s;
            slot_ptr = (slot_ptr + 1 >= n) ? 0 : slot_ptr + 1;
            last_median = ring_median(n);
        end
        return last_median;
    endfunction

    always @(posedge i_clk) begin
        logic signed [SB-1:0] want;
        if (!i_rst_n) begin
            win_len = gmed_pkg::LEN_RESET;
            clear_ring();
            pending_medians.delete();
            fails   = 0;
            items   = 0;
            results = 0;
        end else begin
            // output first: a result can never belong to a same-edge input
            if (i_out_valid && i_out_ready) begin
                results++;
                if (pending_medians.size() == 0) begin
                    $display("%0t ERROR unexpected median: expected none actual %0d",
                             $time, i_median_value);
                    fails++;
                end else begin
                    want = pending_medians.pop_front();
                    if (want !== i_median_value) begin
                        $display("%0t ERROR median mismatch: expected %0d actual %0d",
                                 $time, want, i_median_value);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                win_len = i_cfg_wr_data;
                clear_ring();
            end
            if (i_in_valid && i_in_ready) begin
                pending_medians.push_back(take_sample(i_sample, i_trigger));
                items++;
            end
        end
        o_fail_count   <= fails;
        o_pending      <= pending_medians.size();
        o_item_count   <= items;
        o_result_count <= results;
    end

endmodule

// ===== dv/gated_running_median_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_running_median_test
// Drives sample transactions and window_length writes into the gated running
// median block, with random gaps and output back-pressure, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module gated_running_median_test;

    localparam int SB = gmed_pkg::SAMPLE_BITS_DEF;
    localparam int CW = gmed_pkg::CFG_BITS;
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [gmed_pkg::CFG_BITS-1:0]      i_cfg_wr_data;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic signed [SB-1:0]               i_sample;
    logic                               i_trigger;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic signed [SB-1:0]               o_median_value;

    int fail_count;
    int pending;
    int item_count;
    int result_count;

    // stimulus bookkeeping, owned by the main process
    int trig_sent;
    int settings;
    bit quiet;    // no idling on either side once set

    gated_running_median u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_trigger      (i_trigger),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_median_value (o_median_value)
    );

    gated_running_median_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .i_trigger      (i_trigger),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_median_value (o_median_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_item_count   (item_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. The slowest legal run (about 750 transactions plus gaps, stalls
    // and the long hold) ends well inside 5 ms, so the margin is wide.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts; one long hold-off early in the run so
    // the output register and the compute slot fill up and the input stalls.
    // Each branch makes one assignment to i_out_ready and then waits on the clock.
    // ------------------------------------------------------------------------
    initial begin
        bit held_off;
        held_off = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && item_count >= 60) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one input transaction; valid stays up across back-to-back calls
    task automatic send_item(input logic signed [SB-1:0] value, input logic trig);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        i_trigger  <= trig;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (trig)
            trig_sent++;
    endtask

    // stop offering input and wait until every predicted median came out;
    // the first edge lets the checker count the last accepted transaction
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write only with the block idle; it also clears the ring
    task automatic set_window_length(input logic [gmed_pkg::CFG_BITS-1:0] len);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    // mix of extremes, a tight band that breeds duplicates, and full range
    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SB'(int'($urandom_range(0, 16)) - 8);
            3:       return '0;
            default: return SB'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [gmed_pkg::CFG_BITS-1:0] len;
        int                            n_eff;
        int                            rand_sent;
        int                            phase;
        int                            fixed_lens [6];

        fixed_lens = '{64, 1, 127, 0, 2, 3};
        trig_sent  = 0;
        settings   = 0;
        rand_sent  = 0;
        quiet      = 1'b0;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_sample      <= '0;
        i_trigger     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset length of 64: mostly zeros, so the median stays zero
        send_item(SB'(123), 1'b0);
        send_item(SAMPLE_MAX, 1'b1);
        send_item(SAMPLE_MIN, 1'b1);

        // length 2: averaging at full scale, floor rounding of odd sums
        set_window_length(2);
        send_item(SAMPLE_MAX, 1'b1);
        send_item(SAMPLE_MAX, 1'b1);
        send_item(SAMPLE_MIN, 1'b1);
        send_item(SAMPLE_MIN, 1'b1);
        send_item(SB'(-3), 1'b1);
        send_item(SB'(0), 1'b1);
        send_item(SB'(777), 1'b0);    // trigger clear: held value repeats

        // zero length behaves as one
        set_window_length(0);
        send_item(SB'(5), 1'b1);
        send_item(SB'(-7), 1'b1);
        send_item(SAMPLE_MAX, 1'b0);

        // oversized length clamps to the full store
        set_window_length(127);
        send_item(SB'(100), 1'b1);
        send_item(SB'(-100), 1'b1);

        // odd length with a duplicate being evicted
        set_window_length(3);
        send_item(SB'(1), 1'b1);
        send_item(SB'(1), 1'b1);
        send_item(SB'(-5), 1'b1);
        send_item(SB'(2), 1'b1);
        send_item(SB'(2), 1'b0);

        // --- random phases, each sending twice the window length plus twenty samples ---
        phase = 0;
        while (rand_sent < 600) begin
            len = (phase < 6) ? CW'(fixed_lens[phase]) : CW'($urandom_range(0, 127));
            n_eff = (len == 0) ? 1 : ((len > 64) ? 64 : len);
            set_window_length(len);
            for (int i = 0; i < 2 * n_eff + 20; i++) begin
                send_item(pick_sample(), $urandom_range(0, 4) != 0);
                rand_sent++;
            end
            phase++;
        end

        // --- closing stretch, no idling on either side ---
        set_window_length(5);
        quiet = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(pick_sample(), $urandom_range(0, 4) != 0);

        drain();
        repeat (80) @(posedge i_clk);

        $display("Sent %0d sample transactions (%0d triggered) over %0d window settings,",
                 item_count, trig_sent, settings);
        $display("including zero, even, odd and oversized lengths; %0d medians compared.",
                 result_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gmed_pkg.sv
hdl/gmed_ctrl.sv
hdl/gmed_dpath.sv
hdl/gated_running_median.sv
hdl/gmed_checker.sv
dv/gated_running_median_check.sv
dv/gated_running_median_test.sv
